[hw/rtl/vcib_pkg.sv]
// Shared types and codes for the input VC buffer with route stage.
package vcib_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_ARRIVAL  = 2'd0;
   localparam logic [1:0] CMD_RESPONSE = 2'd1;
   localparam logic [1:0] CMD_PULL     = 2'd2;
   localparam logic [1:0] CMD_TICK     = 2'd3;

   // route stage states, also reported as stage_status
   localparam logic [2:0] ST_EMPTY     = 3'd0;
   localparam logic [2:0] ST_WAIT_REQ  = 3'd1;
   localparam logic [2:0] ST_WAIT_RESP = 3'd2;
   localparam logic [2:0] ST_WAIT_XFER = 3'd3;
   localparam logic [2:0] ST_READY     = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
   localparam logic [1:0] ERR_UNEXP_RESP = 2'd2;
   localparam logic [1:0] ERR_UNEXP_PULL = 2'd3;

   // register indexes
   localparam logic CSR_SOURCE_PORT = 1'b0;
   localparam logic CSR_SOURCE_VC   = 1'b1;

   typedef struct packed {
      logic        head;
      logic [15:0] tag;
   } flit_type;

   typedef struct packed {
      logic        credit_return;
      logic        route_request;
      logic [15:0] request_tag;
      logic        register_packet;
      logic [5:0]  register_out_port;
      logic [3:0]  register_out_vc;
      logic [15:0] register_tag;
      logic [5:0]  report_port;
      logic [3:0]  report_vc;
      logic [2:0]  stage_status;
      logic [4:0]  queue_count;
      logic [1:0]  error_code;
   } rsp_type;

endpackage

[hw/rtl/vcib_flit_fifo.sv]
// Flit FIFO: synchronous memory with read/write pointers and fill count.
module vcib_flit_fifo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  vcib_pkg::flit_type                   push_data,
   input  logic                                 pop,
   output vcib_pkg::flit_type                   pop_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count,
   output logic                                 full,
   output logic                                 empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   vcib_pkg::flit_type flit_store [QUEUE_DEPTH];

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   vcib_pkg::flit_type rd_data_ff;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = rd_data_ff;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         flit_store[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff <= flit_store[rd_ptr_ff];
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fifo count above depth");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty fifo");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full fifo");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("push and pop in the same cycle");
`endif

endmodule

[hw/rtl/vc_input_buffer_route_stage.sv]
// Top level: router input VC buffer with one route-compute stage.
//
// Request channel (req_*): one word per event. req_command selects flit
// arrival, route response, pull grant or clock tick; the flit fields are
// used by arrivals only, the route fields by responses only.
// Response channel (rsp_*): exactly one word per accepted request, in order,
// carrying credit, route request, registration, stage status, FIFO fill
// count and an error code.
// Config port (csr_*): write-only source port / source VC registers, to be written
// only while the block is idle; the block itself does not enforce this.
//
// Flow: for most requests the response word is registered at acceptance and
// shows up in the cycle after it. A tick that pops the FIFO first waits in a
// read phase on the flit memory's registered read port and loads the response
// word after it. One request is in flight at a time.
// A new request is taken in the cycle the held response word is taken.
//
// Reset (synchronous): pointers, fill count, stage state and the response
// valid clear; the flit memory is not cleared (an entry is only read after
// it is written). If the receiver stalls, the response word holds and
// req_ready stays low until it drains.
module vc_input_buffer_route_stage #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        req_flit_is_head,
   input  logic [15:0] req_flit_tag,
   input  logic [5:0]  req_chosen_out_port,
   input  logic [3:0]  req_chosen_out_vc,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_credit_return,
   output logic        rsp_route_request,
   output logic [15:0] rsp_request_tag,
   output logic        rsp_register_packet,
   output logic [5:0]  rsp_register_out_port,
   output logic [3:0]  rsp_register_out_vc,
   output logic [15:0] rsp_register_tag,
   output logic [5:0]  rsp_report_port,
   output logic [3:0]  rsp_report_vc,
   output logic [2:0]  rsp_stage_status,
   output logic [4:0]  rsp_queue_count,
   output logic [1:0]  rsp_error_code,
   // config port
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [5:0]  csr_write_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

   // control phases
   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_READ = 1'b1;   // waiting on flit memory read data

   logic                phase_ff, phase_in;
   logic [2:0]          stage_ff, stage_in;
   vcib_pkg::flit_type  stage_flit_ff, stage_flit_in;
   logic [5:0]          src_port_ff;
   logic [3:0]          src_vc_ff;
   vcib_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_load;

   logic                accept;
   logic                push;
   logic                pop;
   vcib_pkg::flit_type  push_data;
   vcib_pkg::flit_type  pop_data;
   logic [CNT_W-1:0]    fifo_count;
   logic                fifo_full;
   logic                fifo_empty;
   logic [EXT_W-1:0]    cnt_now_ext;
   logic [EXT_W-1:0]    cnt_inc_ext;

   assign req_ready = (phase_ff == PH_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign push_data.head = req_flit_is_head;
   assign push_data.tag  = req_flit_tag;
   assign push = accept && (req_command == vcib_pkg::CMD_ARRIVAL) && !fifo_full;
   // a tick pops when the stage is or becomes empty and the FIFO has a flit
   assign pop  = accept && (req_command == vcib_pkg::CMD_TICK) && !fifo_empty
                 && ((stage_ff == vcib_pkg::ST_EMPTY) || (stage_ff == vcib_pkg::ST_READY));

   vcib_flit_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (fifo_count),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   assign cnt_now_ext = EXT_W'(fifo_count);
   assign cnt_inc_ext = cnt_now_ext + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      stage_in      = stage_ff;
      stage_flit_in = stage_flit_ff;
      rsp_load      = 1'b0;
      rsp_in        = '0;
      rsp_in.queue_count = cnt_now_ext[4:0];

      if (phase_ff == PH_READ) begin
         // popped flit is here; fill count already dropped at accept
         stage_flit_in         = pop_data;
         rsp_in.credit_return  = 1'b1;
         rsp_in.report_port    = src_port_ff;
         rsp_in.report_vc      = src_vc_ff;
         if (pop_data.head) begin
            rsp_in.route_request = 1'b1;
            rsp_in.request_tag   = pop_data.tag;
            stage_in             = vcib_pkg::ST_WAIT_RESP;
         end else begin
            stage_in = vcib_pkg::ST_READY;
         end
         phase_in = PH_IDLE;
         rsp_load = 1'b1;
      end else if (accept) begin
         rsp_load = 1'b1;
         case (req_command)
            vcib_pkg::CMD_ARRIVAL: begin
               if (fifo_full) begin
                  rsp_in.error_code = vcib_pkg::ERR_OVERFLOW;
               end else begin
                  rsp_in.queue_count = cnt_inc_ext[4:0];
               end
            end
            vcib_pkg::CMD_RESPONSE: begin
               if (stage_ff == vcib_pkg::ST_WAIT_RESP) begin
                  stage_in                 = vcib_pkg::ST_WAIT_XFER;
                  rsp_in.register_packet   = 1'b1;
                  rsp_in.register_out_port = req_chosen_out_port;
                  rsp_in.register_out_vc   = req_chosen_out_vc;
                  rsp_in.register_tag      = stage_flit_ff.tag;
                  rsp_in.report_port       = src_port_ff;
                  rsp_in.report_vc         = src_vc_ff;
               end else begin
                  rsp_in.error_code = vcib_pkg::ERR_UNEXP_RESP;
               end
            end
            vcib_pkg::CMD_PULL: begin
               if (stage_ff == vcib_pkg::ST_WAIT_XFER) begin
                  stage_in = vcib_pkg::ST_READY;
               end else begin
                  rsp_in.error_code = vcib_pkg::ERR_UNEXP_PULL;
               end
            end
            default: begin
               // clock tick
               if (pop) begin
                  phase_in = PH_READ;
                  rsp_load = 1'b0;
               end else if (stage_ff == vcib_pkg::ST_READY) begin
                  stage_in      = vcib_pkg::ST_EMPTY;
                  stage_flit_in = '0;
               end
            end
         endcase
      end
      rsp_in.stage_status = stage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         stage_ff      <= vcib_pkg::ST_EMPTY;
         stage_flit_ff <= '0;
         src_port_ff   <= '0;
         src_vc_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         stage_ff      <= stage_in;
         stage_flit_ff <= stage_flit_in;
         if (csr_write_enable) begin
            if (csr_index == vcib_pkg::CSR_SOURCE_PORT) begin
               src_port_ff <= csr_write_data;
            end else begin
               src_vc_ff <= csr_write_data[3:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_credit_return     = rsp_ff.credit_return;
   assign rsp_route_request     = rsp_ff.route_request;
   assign rsp_request_tag       = rsp_ff.request_tag;
   assign rsp_register_packet   = rsp_ff.register_packet;
   assign rsp_register_out_port = rsp_ff.register_out_port;
   assign rsp_register_out_vc   = rsp_ff.register_out_vc;
   assign rsp_register_tag      = rsp_ff.register_tag;
   assign rsp_report_port       = rsp_ff.report_port;
   assign rsp_report_vc         = rsp_ff.report_vc;
   assign rsp_stage_status      = rsp_ff.stage_status;
   assign rsp_queue_count       = rsp_ff.queue_count;
   assign rsp_error_code        = rsp_ff.error_code;

`ifndef SYNTHESIS
   a_read_after_tick: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_READ |-> $past(pop))
      else $error("read phase without a popping tick");
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_READ |=> phase_ff == PH_IDLE && rsp_valid_ff)
      else $error("read phase did not produce a response word");
   a_no_wait_req: assert property (@(posedge clock) disable iff (reset)
      stage_ff != vcib_pkg::ST_WAIT_REQ)
      else $error("stage left in wait-request");
   a_req_means_wait_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.route_request |->
         rsp_ff.stage_status == vcib_pkg::ST_WAIT_RESP && rsp_ff.credit_return)
      else $error("route request without pop into wait-response");
`endif

endmodule

[sim/vc_input_buffer_route_stage_tb.sv]
// Self-checking testbench for the input VC buffer with its route-compute stage.
module vc_input_buffer_route_stage_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH         = 16;
   localparam int WATCHDOG_LIMIT = 2000;  // bound on any legal quiet stretch, with margin
   localparam int SETTLE_CYCLES  = 4;     // covers a popping tick's read phase, plus margin
   localparam int MAX_REPORTS    = 40;

   // ---------------------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ---------------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = vcib_pkg::CMD_TICK;
   logic        req_flit_is_head = 1'b0;
   logic [15:0] req_flit_tag = '0;
   logic [5:0]  req_chosen_out_port = '0;
   logic [3:0]  req_chosen_out_vc = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_credit_return;
   logic        rsp_route_request;
   logic [15:0] rsp_request_tag;
   logic        rsp_register_packet;
   logic [5:0]  rsp_register_out_port;
   logic [3:0]  rsp_register_out_vc;
   logic [15:0] rsp_register_tag;
   logic [5:0]  rsp_report_port;
   logic [3:0]  rsp_report_vc;
   logic [2:0]  rsp_stage_status;
   logic [4:0]  rsp_queue_count;
   logic [1:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = vcib_pkg::CSR_SOURCE_PORT;
   logic [5:0]  csr_write_data = '0;

   vc_input_buffer_route_stage uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor state: the FIFO, the stage and the source registers as seen by the
   // testbench. Updated in acceptance order, so it always matches the block after
   // the last accepted word.
   // ---------------------------------------------------------------------------------
   vcib_pkg::flit_type fifo_model [QDEPTH];
   int                 rd_ptr = 0;
   int                 wr_ptr = 0;
   int                 fill = 0;
   logic [2:0]         stage_st = vcib_pkg::ST_EMPTY;
   vcib_pkg::flit_type stage_flit = '0;
   logic [5:0]         src_port = '0;
   logic [3:0]         src_vc = '0;

   vcib_pkg::rsp_type stage_words_due [$];   // predicted result words, oldest first
   vcib_pkg::rsp_type seen_word;

   // traffic shaping knobs
   bit idle_on = 1'b1;             // sender inserts gaps
   bit stall_on = 1'b1;            // receiver drops rsp_ready now and then
   int body_left = 0;              // body flits still owed by the current packet

   // run statistics
   int n_bad = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_overflow = 0;
   int n_registered = 0;
   int n_settings = 1;
   int idle_cycles = 0;

   // One accepted word through the buffer and stage; returns the result word.
   function automatic vcib_pkg::rsp_type route_stage_step(logic [1:0] cmd, logic head,
                                                          logic [15:0] tag,
                                                          logic [5:0] oport,
                                                          logic [3:0] ovc);
      vcib_pkg::rsp_type r;
      r = '0;
      case (cmd)
         vcib_pkg::CMD_ARRIVAL: begin
            if (fill >= QDEPTH) begin
               r.error_code = vcib_pkg::ERR_OVERFLOW;  // full: flit dropped, no state change
            end else begin
               fifo_model[wr_ptr] = '{head: head, tag: tag};
               wr_ptr = (wr_ptr + 1) % QDEPTH;
               fill++;
            end
         end
         vcib_pkg::CMD_RESPONSE: begin
            if (stage_st == vcib_pkg::ST_WAIT_RESP) begin
               stage_st = vcib_pkg::ST_WAIT_XFER;
               r.register_packet   = 1'b1;
               r.register_out_port = oport;
               r.register_out_vc   = ovc;
               r.register_tag      = stage_flit.tag;
               r.report_port       = src_port;
               r.report_vc         = src_vc;
            end else begin
               r.error_code = vcib_pkg::ERR_UNEXP_RESP;
            end
         end
         vcib_pkg::CMD_PULL: begin
            if (stage_st == vcib_pkg::ST_WAIT_XFER) begin
               stage_st = vcib_pkg::ST_READY;
            end else begin
               r.error_code = vcib_pkg::ERR_UNEXP_PULL;
            end
         end
         vcib_pkg::CMD_TICK: begin
            // clear, then refill, then request or mark ready, all in one tick
            if (stage_st == vcib_pkg::ST_READY) begin
               stage_st = vcib_pkg::ST_EMPTY;
               stage_flit = '0;
            end
            if (stage_st == vcib_pkg::ST_EMPTY && fill > 0) begin
               stage_flit = fifo_model[rd_ptr];
               rd_ptr = (rd_ptr + 1) % QDEPTH;
               fill--;
               r.credit_return = 1'b1;
               r.report_port   = src_port;
               r.report_vc     = src_vc;
               stage_st = vcib_pkg::ST_WAIT_REQ;
            end
            if (stage_st == vcib_pkg::ST_WAIT_REQ) begin
               if (stage_flit.head) begin
                  r.route_request = 1'b1;
                  r.request_tag   = stage_flit.tag;
                  stage_st = vcib_pkg::ST_WAIT_RESP;
               end else begin
                  stage_st = vcib_pkg::ST_READY;
               end
            end
         end
         default: ;
      endcase
      r.stage_status = stage_st;
      r.queue_count  = fill[4:0];
      return r;
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int gap_len(bit enable);
      int r;
      if (!enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(string msg);
      n_bad++;
      if (n_bad <= MAX_REPORTS) $display("MISMATCH: %s", msg);
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: got 0x%0h, want 0x%0h",
                                   n_checked, name, got, want));
   endtask

   task automatic check_word(vcib_pkg::rsp_type got, vcib_pkg::rsp_type want);
      compare_field("credit_return",     16'(got.credit_return),
                    16'(want.credit_return));
      compare_field("route_request",     16'(got.route_request),
                    16'(want.route_request));
      compare_field("request_tag",       got.request_tag,       want.request_tag);
      compare_field("register_packet",   16'(got.register_packet),
                    16'(want.register_packet));
      compare_field("register_out_port", 16'(got.register_out_port),
                    16'(want.register_out_port));
      compare_field("register_out_vc",   16'(got.register_out_vc),
                    16'(want.register_out_vc));
      compare_field("register_tag",      got.register_tag,      want.register_tag);
      compare_field("report_port",       16'(got.report_port),  16'(want.report_port));
      compare_field("report_vc",         16'(got.report_vc),    16'(want.report_vc));
      compare_field("stage_status",      16'(got.stage_status), 16'(want.stage_status));
      compare_field("queue_count",       16'(got.queue_count),  16'(want.queue_count));
      compare_field("error_code",        16'(got.error_code),   16'(want.error_code));
      n_checked++;
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: sampled right after the edge, i.e. the values the block held
   // at the handshake.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = {rsp_credit_return, rsp_route_request, rsp_request_tag,
                      rsp_register_packet, rsp_register_out_port, rsp_register_out_vc,
                      rsp_register_tag, rsp_report_port, rsp_report_vc,
                      rsp_stage_status, rsp_queue_count, rsp_error_code};
         if (stage_words_due.size() == 0)
            report_mismatch($sformatf("result word %0d arrived with none pending", n_checked));
         else
            check_word(seen_word, stage_words_due.pop_front());
      end
   end

   // Receiver back-pressure; ready always returns high before the next stall.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len(1'b1) + 1) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any stretch without a handshake on either channel is bounded.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words pending",
                     WATCHDOG_LIMIT, stage_words_due.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender side. valid stays high after acceptance so back-to-back words never see
   // a low/high pair in one step; hold_sender drops it when a gap is wanted.
   // ---------------------------------------------------------------------------------
   task automatic hold_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_word(logic [1:0] cmd, logic head, logic [15:0] tag,
                            logic [5:0] oport, logic [3:0] ovc);
      int gap;
      vcib_pkg::rsp_type want;
      gap = gap_len(idle_on);
      if (gap > 0) hold_sender(gap);
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_flit_is_head    <= head;
      req_flit_tag        <= tag;
      req_chosen_out_port <= oport;
      req_chosen_out_vc   <= ovc;
      do @(posedge clock); while (!req_ready);
      want = route_stage_step(cmd, head, tag, oport, ovc);
      stage_words_due.push_back(want);
      n_sent++;
      if (want.error_code == vcib_pkg::ERR_OVERFLOW) n_overflow++;
      if (want.register_packet) n_registered++;
   endtask

   // Sender waits until every predicted word has come back, then a little more.
   task automatic drain_results();
      hold_sender(1);
      while (stage_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both source registers, back to back; only called with the block idle.
   task automatic program_source(logic [5:0] port_val, logic [5:0] vc_val);
      csr_write_enable <= 1'b1;
      csr_index        <= vcib_pkg::CSR_SOURCE_PORT;
      csr_write_data   <= port_val;
      @(posedge clock);
      csr_index        <= vcib_pkg::CSR_SOURCE_VC;
      csr_write_data   <= vc_val;     // upper bits may be set: VC register is 4 bits
      @(posedge clock);
      csr_write_enable <= 1'b0;
      src_port = port_val;
      src_vc   = vc_val[3:0];
   endtask

   // Mostly legal traffic: packets of a head plus up to four bodies, responses and
   // pulls only when the stage waits for them. The rest is noise of any command.
   task automatic random_word(int arrival_pct);
      logic [1:0] cmd;
      logic head;
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         cmd  = 2'($urandom_range(0, 3));
         head = 1'($urandom_range(0, 1));
      end else begin
         r = $urandom_range(0, 99);
         if (stage_st == vcib_pkg::ST_WAIT_RESP && r < 45)
            cmd = vcib_pkg::CMD_RESPONSE;
         else if (stage_st == vcib_pkg::ST_WAIT_XFER && r < 45)
            cmd = vcib_pkg::CMD_PULL;
         else if ($urandom_range(0, 99) < arrival_pct)
            cmd = vcib_pkg::CMD_ARRIVAL;
         else
            cmd = vcib_pkg::CMD_TICK;
         head = (body_left == 0);
         if (cmd == vcib_pkg::CMD_ARRIVAL) begin
            if (body_left == 0) body_left = $urandom_range(0, 4);
            else body_left--;
         end
      end
      // fields a command ignores still carry random values
      send_word(cmd, head, 16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
                4'($urandom_range(0, 15)));
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Empty stage: an idle tick changes nothing, a response and a pull are rejected.
   task automatic test_idle_commands();
      send_word(vcib_pkg::CMD_TICK,     1'b1, 16'hFFFF, 6'd63, 4'd15);
      send_word(vcib_pkg::CMD_RESPONSE, 1'b1, 16'hFFFF, 6'd63, 4'd15);
      send_word(vcib_pkg::CMD_PULL,     1'b1, 16'hFFFF, 6'd63, 4'd15);
   endtask

   // Head then body through each stage state the block reports, with out-of-order response and pull.
   task automatic test_head_and_body_flow();
      drain_results();
      program_source(6'd63, 6'h3F);
      n_settings++;
      send_word(vcib_pkg::CMD_ARRIVAL,  1'b1, 16'hFFFF, 6'd0,  4'd0);
      send_word(vcib_pkg::CMD_ARRIVAL,  1'b0, 16'h0000, 6'd63, 4'd15);
      send_word(vcib_pkg::CMD_TICK,     1'b0, 16'h0000, 6'd0,  4'd0);   // pop head, route request
      send_word(vcib_pkg::CMD_RESPONSE, 1'b0, 16'h0000, 6'd63, 4'd15);  // register
      send_word(vcib_pkg::CMD_RESPONSE, 1'b0, 16'h0000, 6'd0,  4'd0);   // not waiting any more
      send_word(vcib_pkg::CMD_PULL,     1'b0, 16'hFFFF, 6'd0,  4'd0);   // pull is tag-blind
      send_word(vcib_pkg::CMD_PULL,     1'b0, 16'h0000, 6'd0,  4'd0);   // already ready
      send_word(vcib_pkg::CMD_TICK,     1'b1, 16'hFFFF, 6'd63, 4'd15);  // clear, pop body
      send_word(vcib_pkg::CMD_TICK,     1'b0, 16'h0000, 6'd0,  4'd0);   // clear, FIFO empty
   endtask

   // Fill all sixteen slots, then two arrivals that must be dropped.
   task automatic test_fifo_overflow();
      for (int i = 0; i < QDEPTH + 2; i++)
         send_word(vcib_pkg::CMD_ARRIVAL, i[0], 16'($urandom_range(0, 65535)), 6'd0, 4'd0);
   endtask

   // One source setting, one traffic mix; the sender drains once mid-phase.
   task automatic test_random_traffic(logic [5:0] port_val, logic [5:0] vc_val,
                                      int arrival_pct, bit idle, bit stall, int count);
      drain_results();
      program_source(port_val, vc_val);
      n_settings++;
      idle_on  = idle;
      stall_on = stall;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results();
         random_word(arrival_pct);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_commands();          // source registers still at reset value
      test_head_and_body_flow();
      test_fifo_overflow();

      // settings: both zero, both at maximum, then random ones; the traffic mix
      // swings from mostly draining to mostly filling
      test_random_traffic(6'd0,  6'd0,  40, 1'b1, 1'b1, 360);
      test_random_traffic(6'd63, 6'h3F, 55, 1'b0, 1'b0, 360);
      test_random_traffic(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          30, 1'b1, 1'b1, 360);
      test_random_traffic(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          65, 1'b1, 1'b0, 360);
      test_random_traffic(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          45, 1'b0, 1'b1, 380);

      drain_results();
      $display("run: %0d words sent, %0d result words checked, %0d source settings",
               n_sent, n_checked, n_settings);
      $display("run: %0d packets registered, %0d flits dropped on a full FIFO",
               n_registered, n_overflow);
      if (n_bad == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d field mismatches", n_bad);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
